/* rtl/core/amf_pkg.sv */
// amf_pkg: shared types, constants and saturating helpers for the arma forecaster
// no dependencies; imported by amf_ram users and arma_multistep_forecaster
package amf_pkg;

  localparam int MAX_LEAD  = 8;
  localparam int LEAD_W    = 3;
  localparam int DATA_W    = 32;
  localparam int COEF_W    = 16;
  localparam int COEF_FRAC = 14;
  localparam int SQ_FRAC   = 16;
  localparam int HIST_D    = 3;
  localparam int PEND_D    = MAX_LEAD * MAX_LEAD;
  localparam int PEND_AW   = 2 * LEAD_W;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [2:0]               cfg_idx_t;

  typedef enum logic [2:0] {
    REG_AR1 = 3'd0,
    REG_AR2 = 3'd1,
    REG_AR3 = 3'd2,
    REG_MA1 = 3'd3,
    REG_MA2 = 3'd4,
    REG_MA3 = 3'd5,
    REG_HOR = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SC_RD,
    ST_SC_SUB,
    ST_SC_SQ,
    ST_SC_ACC,
    ST_FC_MAC,
    ST_FC_FIN,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  function automatic logic signed [63:0] sat_add_s64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic logic [62:0] usat_add63(input logic [62:0] a, input logic [62:0] b);
    logic [63:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[63] ? {63{1'b1}} : s[62:0];
  endfunction

  function automatic data_t clamp_data(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'(2 ** (DATA_W - 1) - 1);
    lo = -hi - 64'sd1;
    if (x > hi) begin
      return hi[DATA_W-1:0];
    end else if (x < lo) begin
      return lo[DATA_W-1:0];
    end
    return x[DATA_W-1:0];
  endfunction

endpackage

/* rtl/core/amf_ram.sv */
// amf_ram: generic single write port, single read port ram with registered read
// no dependencies
module amf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/arma_multistep_forecaster.sv */
// arma_multistep_forecaster: arma multi-lead forecaster with per-lead residual scoring
// depends on amf_pkg and amf_ram
//
// Each input request carries one observed sample and its shock (both signed Q16.16).
// The block first scores the forecasts made earlier that target this sample (residual,
// running sum, absolute sum and squared sum per lead, all saturating), then shifts the
// sample and shock into three-deep histories and forecasts leads 1..horizon with the
// recursive arma equation (Q2.14 coefficients, future shocks taken as zero, rounded half
// up). It then emits one result request per lead, lead 1 first, with last on the final
// lead. Horizon zero acts as 1 and values above 8 act as 8. All arithmetic runs through
// one shared 33x33 multiplier under a small sequencer: scoring passes through read,
// subtract, square and accumulate states per lead that had a stored forecast (the read
// state alone otherwise), forecasting through mac states and a finish state per lead,
// then an update state and the emit state per result. in_ready is low throughout.
// Configuration writes are always ready and take effect immediately; write them only
// while the block is idle.
module arma_multistep_forecaster (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  amf_pkg::data_t           in_sample,
  input  amf_pkg::data_t           in_shock,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [3:0]               out_step,
  output amf_pkg::data_t           out_forecast,
  output amf_pkg::data_t           out_residual,
  output logic                     out_residual_valid,
  output logic signed [63:0]       out_residual_total,
  output logic [62:0]              out_abs_total,
  output logic [62:0]              out_square_total,
  output logic                     out_last,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  amf_pkg::cfg_idx_t        cfg_index,
  input  logic [15:0]              cfg_data
);
  import amf_pkg::*;

  // configuration registers
  coef_t      ar_r [HIST_D];
  coef_t      ma_r [HIST_D];
  logic [3:0] hor_r;

  // sequencer state
  state_t state_r, state_nxt;
  logic [LEAD_W-1:0] k_r;       // current lead minus one
  logic [2:0]        t_r;       // mac term counter
  logic [3:0]        h_r;       // clamped horizon of this item
  logic [LEAD_W-1:0] ptr_r;     // slot pointer

  // item data
  data_t x_r;
  data_t samp_h_r [HIST_D];
  data_t shock_h_r [HIST_D];

  // per-lead working values
  data_t fc_r  [MAX_LEAD];
  data_t res_r [MAX_LEAD];
  logic [MAX_LEAD-1:0] val_r;
  logic [PEND_D-1:0]   pv_r;    // pending forecast valid bits

  // per-lead running statistics
  logic signed [63:0] rsum_r [MAX_LEAD];
  logic [62:0]        asum_r [MAX_LEAD];
  logic [62:0]        ssum_r [MAX_LEAD];

  // shared multiplier and accumulator
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [63:0] prod_r;
  logic signed [63:0] acc_r;
  logic [31:0]        a_r;

  // pending forecast memory
  logic                ram_we;
  logic [PEND_AW-1:0]  ram_waddr, ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;

  logic [LEAD_W-1:0] sc_slot;
  logic              lead_last;
  logic              in_acc;
  logic [LEAD_W-1:0] fc_idx;
  data_t             fc_rd;
  coef_t             op_coef;
  data_t             op_data;
  logic [2:0]        ar_lag;
  logic [2:0]        ma_off;
  logic [3:0]        h_in;
  logic signed [32:0] diff;
  data_t              r_new;
  logic signed [32:0] r_neg;
  logic signed [63:0] rnd;
  logic signed [63:0] sum_fin;
  data_t              fc_new;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign sc_slot   = ptr_r - k_r - LEAD_W'(1);
  assign lead_last = ({1'b0, k_r} == h_r - 4'd1);

  // horizon clamp: zero acts as one, above the lead count saturates
  always_comb begin
    if (hor_r == 4'd0) begin
      h_in = 4'd1;
    end else if (hor_r > 4'(MAX_LEAD)) begin
      h_in = 4'(MAX_LEAD);
    end else begin
      h_in = hor_r;
    end
  end

  // mac operand select: term 0..2 ar lags 1..3, term 3..5 ma lags 1..3
  always_comb begin
    ar_lag  = t_r + 3'd1;
    ma_off  = t_r - 3'd3;
    op_coef = '0;
    op_data = '0;
    fc_idx  = k_r;
    if (t_r < 3'd3) begin
      op_coef = ar_r[t_r[1:0]];
      if (k_r >= ar_lag) begin
        fc_idx  = k_r - ar_lag;     // earlier lead stands in for unseen sample
        op_data = fc_rd;
      end else begin
        op_data = samp_h_r[2'(t_r - k_r)];
      end
    end else if (t_r < 3'd6) begin
      // future shocks count as zero
      if (ma_off >= k_r) begin
        op_coef = ma_r[ma_off[1:0]];
        op_data = shock_h_r[2'(ma_off - k_r)];
      end
    end
    if (state_r == ST_EMIT) begin
      fc_idx = k_r;
    end
  end

  assign fc_rd = fc_r[fc_idx];

  always_comb begin
    if (state_r == ST_SC_SQ) begin
      mul_a = {1'b0, a_r};
      mul_b = {1'b0, a_r};
    end else begin
      mul_a = 33'(op_coef);
      mul_b = 33'(op_data);
    end
  end
  assign mul_p = mul_a * mul_b;

  // residual against stored forecast
  assign diff  = 33'(x_r) - 33'(signed'(ram_rdata));
  assign r_new = clamp_data(64'(diff));
  assign r_neg = -33'(r_new);

  // rounding of the finished dot product
  assign sum_fin = sat_add_s64(acc_r, prod_r);
  assign rnd     = sat_add_s64(acc_r, 64'sd1 <<< (COEF_FRAC - 1)) >>> COEF_FRAC;
  assign fc_new  = clamp_data(rnd);

  assign ram_we    = (state_r == ST_FC_FIN);
  assign ram_waddr = {ptr_r, k_r};
  assign ram_raddr = {sc_slot, k_r};

  amf_ram #(
    .WIDTH(DATA_W),
    .DEPTH(PEND_D)
  ) u_pend (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(fc_new),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SC_RD;
        end
      end
      ST_SC_RD: begin
        if (pv_r[{sc_slot, k_r}]) begin
          state_nxt = ST_SC_SUB;
        end else if (lead_last) begin
          state_nxt = ST_FC_MAC;
        end
      end
      ST_SC_SUB: state_nxt = ST_SC_SQ;
      ST_SC_SQ:  state_nxt = ST_SC_ACC;
      ST_SC_ACC: state_nxt = lead_last ? ST_FC_MAC : ST_SC_RD;
      ST_FC_MAC: begin
        if (t_r == 3'd6) begin
          state_nxt = ST_FC_FIN;
        end
      end
      ST_FC_FIN: state_nxt = lead_last ? ST_UPDATE : ST_FC_MAC;
      ST_UPDATE: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_ready && lead_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST_D; i++) begin
        ar_r[i] <= '0;
        ma_r[i] <= '0;
      end
      hor_r <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_AR1: ar_r[0] <= cfg_data;
        REG_AR2: ar_r[1] <= cfg_data;
        REG_AR3: ar_r[2] <= cfg_data;
        REG_MA1: ma_r[0] <= cfg_data;
        REG_MA2: ma_r[1] <= cfg_data;
        REG_MA3: ma_r[2] <= cfg_data;
        REG_HOR: hor_r   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r   <= '0;
      t_r   <= '0;
      h_r   <= 4'd1;
      ptr_r <= '0;
      pv_r  <= '0;
      val_r <= '0;
      for (int i = 0; i < HIST_D; i++) begin
        samp_h_r[i]  <= '0;
        shock_h_r[i] <= '0;
      end
      for (int i = 0; i < MAX_LEAD; i++) begin
        rsum_r[i] <= '0;
        asum_r[i] <= '0;
        ssum_r[i] <= '0;
      end
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            x_r          <= in_sample;
            h_r          <= h_in;
            k_r          <= '0;
            samp_h_r[2]  <= samp_h_r[1];
            samp_h_r[1]  <= samp_h_r[0];
            samp_h_r[0]  <= in_sample;
            shock_h_r[2] <= shock_h_r[1];
            shock_h_r[1] <= shock_h_r[0];
            shock_h_r[0] <= in_shock;
          end
        end
        ST_SC_RD: begin
          if (!pv_r[{sc_slot, k_r}]) begin
            // no earlier forecast: report zero, sums untouched
            val_r[k_r] <= 1'b0;
            res_r[k_r] <= '0;
            k_r        <= lead_last ? '0 : k_r + LEAD_W'(1);
            t_r        <= '0;
            acc_r      <= '0;
          end
        end
        ST_SC_SUB: begin
          val_r[k_r] <= 1'b1;
          res_r[k_r] <= r_new;
          a_r        <= r_new[DATA_W-1] ? r_neg[31:0] : r_new;
        end
        ST_SC_SQ: begin
          prod_r <= mul_p[63:0];
        end
        ST_SC_ACC: begin
          rsum_r[k_r] <= sat_add_s64(rsum_r[k_r], 64'(res_r[k_r]));
          asum_r[k_r] <= usat_add63(asum_r[k_r], 63'(a_r));
          ssum_r[k_r] <= usat_add63(ssum_r[k_r], 63'(prod_r[63:SQ_FRAC]));
          k_r         <= lead_last ? '0 : k_r + LEAD_W'(1);
          t_r         <= '0;
          acc_r       <= '0;
        end
        ST_FC_MAC: begin
          prod_r <= mul_p[63:0];
          if (t_r != 3'd0) begin
            acc_r <= sum_fin;
          end
          t_r <= t_r + 3'd1;
        end
        ST_FC_FIN: begin
          fc_r[k_r] <= fc_new;
          k_r       <= lead_last ? '0 : k_r + LEAD_W'(1);
          t_r       <= '0;
          acc_r     <= '0;
        end
        ST_UPDATE: begin
          // mark this slot's leads below the horizon as pending
          for (int i = 0; i < MAX_LEAD; i++) begin
            pv_r[{ptr_r, LEAD_W'(i)}] <= (i < int'(h_r));
          end
          ptr_r <= ptr_r + LEAD_W'(1);
          k_r   <= '0;
        end
        ST_EMIT: begin
          if (out_ready && !lead_last) begin
            k_r <= k_r + LEAD_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // result request, held stable from registers until taken
  assign out_valid          = (state_r == ST_EMIT);
  assign out_step           = {1'b0, k_r} + 4'd1;
  assign out_forecast       = fc_rd;
  assign out_residual       = res_r[k_r];
  assign out_residual_valid = val_r[k_r];
  assign out_residual_total = rsum_r[k_r];
  assign out_abs_total      = asum_r[k_r];
  assign out_square_total   = ssum_r[k_r];
  assign out_last           = out_valid && lead_last;

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while results pending");

  a_lead_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_step == $past(out_step) + 4'd1)
    else $error("result leads out of order");

  a_res_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_residual_valid |-> out_residual == '0)
    else $error("unscored residual not zero");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready after request accepted");

endmodule

/* tb/arma_multistep_forecaster_tb.sv */
// arma_multistep_forecaster_tb: self-checking bench for the arma multi-lead forecaster
// depends on amf_pkg and arma_multistep_forecaster; scores every result request against
// an in-bench predictor under random source gaps and sink stalls
module arma_multistep_forecaster_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import amf_pkg::*;

  localparam cfg_idx_t REG_UNUSED = 3'd7;
  localparam longint S64_MAX = 64'sh7fffffffffffffff;
  localparam longint S64_MIN = 64'sh8000000000000000;
  localparam longint U63_MAX = 64'sh7fffffffffffffff;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic [3:0]         step;
    data_t              forecast;
    data_t              residual;
    logic               rvalid;
    logic signed [63:0] rtotal;
    logic [62:0]        abs_tot;
    logic [62:0]        sq_tot;
    logic               last;
  } lead_result_t;

  typedef struct {
    data_t sample;
    data_t shock;
  } obs_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  data_t in_sample = '0;
  data_t in_shock = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] out_step;
  data_t out_forecast;
  data_t out_residual;
  logic out_residual_valid;
  logic signed [63:0] out_residual_total;
  logic [62:0] out_abs_total;
  logic [62:0] out_square_total;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = '0;
  logic [15:0] cfg_data = '0;

  arma_multistep_forecaster uut (.*);

  always #6 clk = ~clk;

  // predictor state
  longint ar_w[3];
  longint ma_w[3];
  logic [3:0] hor_reg;
  longint x_hist[3];
  longint e_hist[3];
  longint held_fc[8][8];
  bit held_ok[8][8];
  longint res_sum[8];
  longint abs_sum[8];
  longint sq_sum[8];
  int slot_ptr;

  obs_t obs_queue[$];
  lead_result_t lead_queue[$];
  int errors = 0;
  int accepted = 0;
  bit took = 1'b0;

  function automatic longint sadd(longint a, longint b);
    longint s;
    s = a + b;
    if (a >= 0 && b >= 0 && s < 0) return S64_MAX;
    if (a < 0 && b < 0 && s >= 0) return S64_MIN;
    return s;
  endfunction

  // both operands lie in 0..2^63-1, so overflow shows as a negative sum
  function automatic longint uadd63(longint a, longint b);
    longint s;
    s = a + b;
    return (s < 0) ? U63_MAX : s;
  endfunction

  function automatic longint clampd(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("ERROR %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic model_reset();
    for (int i = 0; i < 3; i++) begin
      ar_w[i] = 0; ma_w[i] = 0; x_hist[i] = 0; e_hist[i] = 0;
    end
    for (int i = 0; i < 8; i++) begin
      res_sum[i] = 0; abs_sum[i] = 0; sq_sum[i] = 0;
      for (int j = 0; j < 8; j++) held_ok[i][j] = 1'b0;
    end
    hor_reg = 4'd1;
    slot_ptr = 0;
  endtask

  task automatic model_config(cfg_idx_t idx, logic [15:0] val);
    longint c;
    c = longint'($signed(val));
    case (idx)
      REG_AR1: ar_w[0] = c;
      REG_AR2: ar_w[1] = c;
      REG_AR3: ar_w[2] = c;
      REG_MA1: ma_w[0] = c;
      REG_MA2: ma_w[1] = c;
      REG_MA3: ma_w[2] = c;
      REG_HOR: hor_reg = val[3:0];
      default: ;
    endcase
  endtask

  // scores earlier forecasts on this sample, then forecasts the next leads
  task automatic forecast_and_score(data_t xs, data_t es);
    longint x, r, a, acc, v;
    longint fc[8];
    longint res[8];
    bit ok[8];
    int h, slot;
    lead_result_t lr;
    x = longint'(xs);
    h = (hor_reg == 0) ? 1 : (hor_reg > 8) ? 8 : int'(hor_reg);
    for (int k = 1; k <= h; k++) begin
      slot = (slot_ptr - k) & 7;
      ok[k-1] = held_ok[slot][k-1];
      res[k-1] = 0;
      if (ok[k-1]) begin
        r = clampd(x - held_fc[slot][k-1]);
        a = (r < 0) ? -r : r;
        res[k-1] = r;
        res_sum[k-1] = sadd(res_sum[k-1], r);
        abs_sum[k-1] = uadd63(abs_sum[k-1], a);
        sq_sum[k-1] = uadd63(sq_sum[k-1], (a * a) >>> 16);
      end
    end
    x_hist[2] = x_hist[1]; x_hist[1] = x_hist[0]; x_hist[0] = x;
    e_hist[2] = e_hist[1]; e_hist[1] = e_hist[0]; e_hist[0] = longint'(es);
    for (int k = 1; k <= h; k++) begin
      acc = 0;
      for (int j = 1; j <= 3; j++) begin
        v = (k > j) ? fc[k-j-1] : x_hist[j-k];
        acc = sadd(acc, ar_w[j-1] * v);
      end
      // shocks not yet seen count as zero
      for (int j = k; j <= 3; j++) acc = sadd(acc, ma_w[j-1] * e_hist[j-k]);
      acc = sadd(acc, 64'sd8192);
      fc[k-1] = clampd(acc >>> 14);
    end
    for (int k = 0; k < 8; k++) begin
      held_ok[slot_ptr][k] = (k < h);
      if (k < h) held_fc[slot_ptr][k] = fc[k];
    end
    slot_ptr = (slot_ptr + 1) & 7;
    for (int k = 0; k < h; k++) begin
      lr.step = 4'(k + 1);
      lr.forecast = data_t'(fc[k]);
      lr.residual = data_t'(res[k]);
      lr.rvalid = ok[k];
      lr.rtotal = res_sum[k];
      lr.abs_tot = abs_sum[k][62:0];
      lr.sq_tot = sq_sum[k][62:0];
      lr.last = (k + 1 == h);
      lead_queue = {lead_queue, lr};
    end
  endtask

  // acceptance and result checking at the rising edge
  always @(posedge clk) begin
    lead_result_t w;
    took <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      accepted++;
      forecast_and_score(in_sample, in_shock);
    end
    if (rst_n && out_valid && out_ready) begin
      if (lead_queue.size() == 0) begin
        report("result request with nothing expected", out_step, 0);
      end else begin
        w = lead_queue.pop_front();
        if (out_step !== w.step) report("step", out_step, w.step);
        if (out_forecast !== w.forecast) report("forecast", out_forecast, w.forecast);
        if (out_residual !== w.residual) report("residual", out_residual, w.residual);
        if (out_residual_valid !== w.rvalid)
          report("residual_valid", out_residual_valid, w.rvalid);
        if (out_residual_total !== w.rtotal)
          report("residual_total", out_residual_total, w.rtotal);
        if (out_abs_total !== w.abs_tot) report("abs_total", out_abs_total, w.abs_tot);
        if (out_square_total !== w.sq_tot)
          report("square_total", out_square_total, w.sq_tot);
        if (out_last !== w.last) report("last", out_last, w.last);
      end
    end
  end

  // source: bursts of requests with random gaps between them
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    obs_t o;
    if (rst_n && (!in_valid || took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (obs_queue.size() > 0) begin
        o = obs_queue.pop_front();
        in_sample <= o.sample;
        in_shock <= o.shock;
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 6);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // sink: pattern of its own, re-rolled each time pat_cnt wraps, plus one long hold-off
  logic [15:0] ready_pat = 16'hffff;
  int pat_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(negedge clk) begin
    if (!hold_done && accepted >= 40) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (pat_cnt == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pat = 16'hffff;
        1: ready_pat = 16'($urandom);
        2: ready_pat = 16'h0001 << $urandom_range(0, 15);
        default: ready_pat = ~(16'h0003 << $urandom_range(0, 14));
      endcase
    end
    pat_cnt = (pat_cnt + 1) & 63;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ready_pat[pat_cnt & 15];
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    model_config(idx, val);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_coefs(logic [15:0] a1, logic [15:0] a2, logic [15:0] a3,
                             logic [15:0] m1, logic [15:0] m2, logic [15:0] m3);
    write_reg(REG_AR1, a1);
    write_reg(REG_AR2, a2);
    write_reg(REG_AR3, a3);
    write_reg(REG_MA1, m1);
    write_reg(REG_MA2, m2);
    write_reg(REG_MA3, m3);
  endtask

  task automatic push_obs(data_t s, data_t e);
    obs_t o;
    o.sample = s;
    o.shock = e;
    obs_queue = {obs_queue, o};
  endtask

  // mostly moderate q16.16 values, sometimes full range or extremes
  function automatic data_t rand_data();
    case ($urandom_range(0, 7))
      0: return data_t'($urandom);
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return '0;
      default: return data_t'(int'($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
    endcase
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'(int'($urandom_range(0, 16'h2000)) - 16'h1000);
    endcase
  endfunction

  // wait until every queued request is taken and every result has come back
  task automatic drain();
    do @(posedge clk); while (obs_queue.size() != 0 || in_valid || lead_queue.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    model_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults: horizon 1, all coefficients zero
    push_obs(32'sh7fffffff, 32'sh80000000);
    push_obs(32'sh80000000, 32'sh7fffffff);
    push_obs(32'sh00010000, 32'shffff0000);
    drain();

    // extreme coefficients at full horizon drive the forecast into saturation
    write_coefs(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
    write_reg(REG_HOR, 16'd8);
    end_writes();
    push_obs(32'sh7fffffff, 32'sh80000000);
    push_obs(32'sh7fffffff, 32'sh7fffffff);
    push_obs(32'sh80000000, 32'sh80000000);
    push_obs(32'sh80000000, 32'sh7fffffff);
    push_obs(32'sh7fffffff, 32'sh00000000);
    drain();

    // horizon zero acts as one; unknown register index is ignored
    write_coefs(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    write_reg(REG_HOR, 16'hfff0);
    write_reg(REG_UNUSED, 16'hffff);
    end_writes();
    push_obs(32'sh00020000, 32'sh00010000);
    push_obs(32'sh80000000, 32'sh7fffffff);
    push_obs(32'sh7fffffff, 32'sh80000000);
    drain();

    // horizon above eight saturates to eight
    write_coefs(16'h4000, 16'he000, 16'h1000, 16'h2000, 16'hf000, 16'h0800);
    write_reg(REG_HOR, 16'h000f);
    end_writes();
    for (int i = 0; i < 5; i++) push_obs(data_t'(i * 32'sh00030000), 32'sh00008000);
    drain();

    // shorter horizon leaves higher leads unscored, longer one finds gaps where leads above three were not stored
    write_reg(REG_HOR, 16'd3);
    end_writes();
    for (int i = 0; i < 4; i++) push_obs(32'sh00050000, 32'shfffc0000);
    drain();
    write_reg(REG_HOR, 16'd6);
    end_writes();
    for (int i = 0; i < 4; i++) push_obs(32'shfffb0000, 32'sh00040000);
    drain();

    // random phases, each with fresh coefficients and horizon
    for (int p = 0; p < 8; p++) begin
      write_coefs(rand_coef(), rand_coef(), rand_coef(),
                  rand_coef(), rand_coef(), rand_coef());
      write_reg(REG_HOR, (p == 0) ? 16'd8 : (p == 1) ? 16'd1 :
                16'($urandom_range(0, 16'hffff)));
      end_writes();
      for (int i = 0; i < 20; i++) push_obs(rand_data(), rand_data());
      drain();
    end

    repeat (120) @(posedge clk);
    if (lead_queue.size() != 0) report("results never delivered", lead_queue.size(), 0);
    if (errors == 0) begin
      $display("arma_multistep_forecaster: match");
    end else begin
      $display("arma_multistep_forecaster: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("arma_multistep_forecaster: mismatch");
    $finish;
  end

endmodule

/* arma_multistep_forecaster.f */
rtl/core/amf_pkg.sv
rtl/core/amf_ram.sv
rtl/core/arma_multistep_forecaster.sv
tb/arma_multistep_forecaster_tb.sv
